/* rtl/ws_ser_pkg.sv */
// Shared types, register codes and reset values for the pixel serializer.
`default_nettype none

package ws_ser_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_ONE_HIGH   = 2'd0;
   localparam logic [1:0] CSR_ZERO_HIGH  = 2'd1;
   localparam logic [1:0] CSR_BIT_PERIOD = 2'd2;
   localparam logic [1:0] CSR_LATCH_GAP  = 2'd3;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned SLOT_W      = 12;
   localparam int unsigned GAP_W       = 16;
   localparam int unsigned PIXEL_BITS  = 24;
   localparam int unsigned BITS_LEFT_W = 5;

   // Register reset values
   localparam logic [SLOT_W-1:0] ONE_HIGH_RESET   = 12'd40;
   localparam logic [SLOT_W-1:0] ZERO_HIGH_RESET  = 12'd20;
   localparam logic [SLOT_W-1:0] BIT_PERIOD_RESET = 12'd63;
   localparam logic [GAP_W-1:0]  LATCH_GAP_RESET  = 16'd3000;

   // Shortest bit slot the line can produce
   localparam logic [SLOT_W-1:0] MIN_PERIOD = 12'd2;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_SEND = 2'd1,
      MODE_GAP  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [SLOT_W-1:0] one_high;
      logic [SLOT_W-1:0] zero_high;
      logic [SLOT_W-1:0] bit_period;
      logic [GAP_W-1:0]  latch_gap;
   } cfg_type;

   typedef struct packed {
      logic       pixel_valid;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic       frame_last;
   } item_type;

   typedef struct packed {
      logic line_level;
      logic ready_res;
      logic accepted;
      logic dropped;
      logic frame_done;
   } result_type;

endpackage

`default_nettype wire

/* rtl/ws_ser_core.sv */
// Serializer state and per-tick next-state logic for the one-wire LED line.
`default_nettype none

module ws_ser_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire ws_ser_pkg::cfg_type    cfg,
   input  wire ws_ser_pkg::item_type   item,
   output ws_ser_pkg::result_type      result
);

   logic [ws_ser_pkg::PIXEL_BITS-1:0]  shift_ff, shift_in;
   logic [ws_ser_pkg::BITS_LEFT_W-1:0] bits_left_ff, bits_left_in;
   logic [ws_ser_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [ws_ser_pkg::GAP_W-1:0]       gap_ff, gap_in;
   ws_ser_pkg::mode_type               mode_ff, mode_in;
   logic                               end_pending_ff, end_pending_in;

   logic [ws_ser_pkg::SLOT_W-1:0] period;
   logic [ws_ser_pkg::SLOT_W-1:0] high_raw;
   logic [ws_ser_pkg::SLOT_W-1:0] high_time;
   logic [ws_ser_pkg::SLOT_W-1:0] slot_inc;
   logic [ws_ser_pkg::GAP_W-1:0]  gap_limit;
   logic [ws_ser_pkg::GAP_W-1:0]  gap_inc;

   // Slot timing, clamped to a usable period and high time
   always_comb begin
      period    = (cfg.bit_period < ws_ser_pkg::MIN_PERIOD) ? ws_ser_pkg::MIN_PERIOD
                                                            : cfg.bit_period;
      high_raw  = shift_ff[ws_ser_pkg::PIXEL_BITS-1] ? cfg.one_high : cfg.zero_high;
      high_time = (high_raw >= period) ? (period - 12'd1) : high_raw;
      slot_inc  = slot_ff + 12'd1;
      gap_limit = (cfg.latch_gap == '0) ? 16'd1 : cfg.latch_gap;
      gap_inc   = gap_ff + 16'd1;
   end

   // Next state and result for the current tick
   always_comb begin
      shift_in       = shift_ff;
      bits_left_in   = bits_left_ff;
      slot_in        = slot_ff;
      gap_in         = gap_ff;
      mode_in        = mode_ff;
      end_pending_in = end_pending_ff;
      result         = '0;
      case (mode_ff)
         ws_ser_pkg::MODE_SEND: begin
            result.line_level = (slot_ff < high_time);
            result.dropped    = item.pixel_valid;
            slot_in           = slot_inc;
            if ((slot_inc >= period) || (slot_inc == '0)) begin
               slot_in  = '0;
               shift_in = {shift_ff[ws_ser_pkg::PIXEL_BITS-2:0], 1'b0};
               if (bits_left_ff <= 5'd1) begin
                  bits_left_in = '0;
                  if (end_pending_ff) begin
                     mode_in = ws_ser_pkg::MODE_GAP;
                     gap_in  = '0;
                  end else begin
                     mode_in = ws_ser_pkg::MODE_IDLE;
                  end
               end else begin
                  bits_left_in = bits_left_ff - 5'd1;
               end
            end
         end
         ws_ser_pkg::MODE_GAP: begin
            result.dropped = item.pixel_valid;
            gap_in         = gap_inc;
            if ((gap_inc >= gap_limit) || (gap_inc == '0)) begin
               gap_in            = '0;
               mode_in           = ws_ser_pkg::MODE_IDLE;
               end_pending_in    = 1'b0;
               result.frame_done = 1'b1;
            end
         end
         default: begin
            // idle, and the unused code behaves the same
            result.ready_res = 1'b1;
            mode_in          = ws_ser_pkg::MODE_IDLE;
            if (item.pixel_valid) begin
               result.accepted = 1'b1;
               shift_in        = {item.green, item.red, item.blue};
               bits_left_in    = 5'(ws_ser_pkg::PIXEL_BITS);
               slot_in         = '0;
               end_pending_in  = item.frame_last;
               mode_in         = ws_ser_pkg::MODE_SEND;
            end
         end
      endcase
   end

   // State registers advance once per processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff       <= '0;
         bits_left_ff   <= '0;
         slot_ff        <= '0;
         gap_ff         <= '0;
         mode_ff        <= ws_ser_pkg::MODE_IDLE;
         end_pending_ff <= 1'b0;
      end else if (step) begin
         shift_ff       <= shift_in;
         bits_left_ff   <= bits_left_in;
         slot_ff        <= slot_in;
         gap_ff         <= gap_in;
         mode_ff        <= mode_in;
         end_pending_ff <= end_pending_in;
      end
   end

   // A pixel in flight always has bits left to send
   a_send_bits: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ws_ser_pkg::MODE_SEND |-> bits_left_ff != '0)
      else $error("send mode with no bits left");

   // The latch gap is only entered for a frame's last pixel
   a_gap_pending: assert property (@(posedge clock) disable iff (reset)
      mode_ff == ws_ser_pkg::MODE_GAP |-> end_pending_ff)
      else $error("latch gap without a frame end");

   // A slot count never reaches the effective period
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == ws_ser_pkg::MODE_SEND && $stable(cfg)) |-> slot_ff < period ||
      !$past(step))
      else $error("slot count past period");

   // Accepting a pixel loads a full pixel worth of bits
   a_load: assert property (@(posedge clock) disable iff (reset)
      (step && result.accepted) |=> bits_left_ff == 5'(ws_ser_pkg::PIXEL_BITS))
      else $error("pixel load lost its bit count");

endmodule

`default_nettype wire

/* rtl/ws2812_pixel_serializer.sv */
// Top level: config registers, input register, serializer core and result register.
`default_nettype none

// Channel    Ports                    Moves
// ---------  -----------------------  ------------------------------------------
// request    req_valid / req_ready    one tick: pixel offer, colors, frame end
// response   rsp_valid / rsp_ready    one tick: line level and status flags
// config     csr_wr_en               register write, index and data, no wait
//
// One transaction in, one transaction out, one per cycle sustained while rsp_ready holds.
// A request passes through two registers: input register, then result register.
// Serializer state advances only when a request transaction is processed.
// A stalled response holds the input register; nothing is dropped or repeated.
// Synchronous reset clears all control state and restores register defaults.

module ws2812_pixel_serializer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_pixel_valid,
   input  wire logic [7:0]                         req_green,
   input  wire logic [7:0]                         req_red,
   input  wire logic [7:0]                         req_blue,
   input  wire logic                               req_frame_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_line_level,
   output logic                                    rsp_ready_res,
   output logic                                    rsp_accepted,
   output logic                                    rsp_dropped,
   output logic                                    rsp_frame_done,
   input  wire logic                               csr_wr_en,
   input  wire logic [ws_ser_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ws_ser_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ws_ser_pkg::cfg_type    cfg_ff;
   ws_ser_pkg::item_type   in_item_ff;
   logic                   in_valid_ff;
   ws_ser_pkg::result_type rsp_item_ff;
   logic                   rsp_valid_ff;
   ws_ser_pkg::result_type core_result;
   logic                   advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high   <= ws_ser_pkg::ONE_HIGH_RESET;
         cfg_ff.zero_high  <= ws_ser_pkg::ZERO_HIGH_RESET;
         cfg_ff.bit_period <= ws_ser_pkg::BIT_PERIOD_RESET;
         cfg_ff.latch_gap  <= ws_ser_pkg::LATCH_GAP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ws_ser_pkg::CSR_ONE_HIGH:   cfg_ff.one_high   <= csr_wdata[11:0];
            ws_ser_pkg::CSR_ZERO_HIGH:  cfg_ff.zero_high  <= csr_wdata[11:0];
            ws_ser_pkg::CSR_BIT_PERIOD: cfg_ff.bit_period <= csr_wdata[11:0];
            ws_ser_pkg::CSR_LATCH_GAP:  cfg_ff.latch_gap  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Process the held transaction whenever the result register can take it
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{pixel_valid: req_pixel_valid, green: req_green, red: req_red,
                         blue: req_blue, frame_last: req_frame_last};
      end
   end

   ws_ser_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg_ff),
      .item   (in_item_ff),
      .result (core_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = rsp_item_ff.line_level;
   assign rsp_ready_res  = rsp_item_ff.ready_res;
   assign rsp_accepted   = rsp_item_ff.accepted;
   assign rsp_dropped    = rsp_item_ff.dropped;
   assign rsp_frame_done = rsp_item_ff.frame_done;

endmodule

`default_nettype wire
